// ===== src/mst_pkg.sv =====
// Shared types and constants for the spanning-tree cost block.
`timescale 1ns / 1ps

package mst_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam int VTX_W    = 6;
  localparam int VCNT_W   = 7;
  localparam int WIN_W    = 32;
  localparam int COST_W   = 38;
  localparam int ACT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic clr_wr;
    logic add_rd;
    logic add_wr_ab;
    logic add_wr_ba;
    logic run_init;
    logic take_src;
    logic pass_step;
    logic take;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic add_upd;
    logic n_zero;
    logic src_bad;
    logic issue_last;
    logic all_taken;
    logic found;
  } status_t;

endpackage

// ===== src/mst_dp.sv =====
// Datapath: config registers, edge store, distance store, scan and cost accumulator.
`timescale 1ns / 1ps

module mst_dp #(
  parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mst_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [mst_pkg::VTX_W-1:0]          vertex_a_i,
  input  logic [mst_pkg::VTX_W-1:0]          vertex_b_i,
  input  logic signed [mst_pkg::WIN_W-1:0]   edge_weight_i,
  input  mst_pkg::cmd_t                      cmd_i,
  input  logic                               disc_i,
  output mst_pkg::status_t                   status_o,
  output logic signed [mst_pkg::COST_W-1:0]  total_cost_o,
  output logic                               disconnected_o
);
  import mst_pkg::*;

  localparam int WW    = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);

  logic [VCNT_W-1:0] vc_q;
  logic [VTX_W-1:0]  src_q;
  logic [NW-1:0]     n;

  logic [AW-1:0]        ab_q, ba_q;
  logic signed [WW-1:0] w_q;
  logic                 in_range_q;

  logic [AW-1:0] clr_idx_q;

  logic [WW:0]   edge_mem [DEPTH];
  logic [WW:0]   edge_rd_q;
  logic          edge_we;
  logic [AW-1:0] edge_waddr;
  logic [WW:0]   edge_wdata;
  logic [AW-1:0] edge_raddr;

  logic signed [WW-1:0] dist_mem [MAX_VERTICES];
  logic signed [WW-1:0] dist_rd_q;

  logic [MAX_VERTICES-1:0] visited_q, known_q;
  logic [VW-1:0]           u_q, i_q, p1_i_q, best_q;
  logic                    p1_v_q, found_q;
  logic signed [WW-1:0]    best_d_q;
  logic [NW-1:0]           taken_q;
  logic [COST_W-1:0]       cost_q;

  logic                 pres, vis, kn, upd, cand;
  logic signed [WW-1:0] rw, eff;

  // Clamp the vertex count to the store size
  always_comb begin
    if (int'(vc_q) > MAX_VERTICES) n = NW'(MAX_VERTICES);
    else                           n = NW'(vc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= VCNT_RESET;
      src_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_COUNT:  vc_q  <= cfg_data_i;
        REG_SOURCE_VERTEX: src_q <= cfg_data_i[VTX_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture an add-edge transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      ab_q <= AW'(int'(vertex_a_i) * MAX_VERTICES + int'(vertex_b_i));
      ba_q <= AW'(int'(vertex_b_i) * MAX_VERTICES + int'(vertex_a_i));
      w_q  <= edge_weight_i[WW-1:0];
      in_range_q <= (int'(vertex_a_i) < MAX_VERTICES) && (int'(vertex_b_i) < MAX_VERTICES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_idx_q <= status_o.clr_last ? '0 : clr_idx_q + AW'(1);
    end
  end

  // Edge store write and read ports
  always_comb begin
    edge_we    = cmd_i.clr_wr | cmd_i.add_wr_ab | cmd_i.add_wr_ba;
    edge_waddr = cmd_i.clr_wr ? clr_idx_q : (cmd_i.add_wr_ab ? ab_q : ba_q);
    edge_wdata = cmd_i.clr_wr ? '0 : {1'b1, w_q};
    edge_raddr = cmd_i.add_rd ? ab_q : AW'(int'(u_q) * MAX_VERTICES + int'(i_q));
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rd_q <= edge_mem[edge_raddr];
  end

  // Relax stage: one neighbor per cycle, tracking the next minimum
  always_comb begin
    pres = edge_rd_q[WW];
    rw   = edge_rd_q[WW-1:0];
    vis  = visited_q[p1_i_q];
    kn   = known_q[p1_i_q];
    upd  = p1_v_q && !vis && pres && (!kn || (rw < dist_rd_q));
    eff  = upd ? rw : dist_rd_q;
    cand = p1_v_q && !vis && (kn || upd);
  end

  always_ff @(posedge clk_i) begin
    if (upd) dist_mem[p1_i_q] <= rw;
    dist_rd_q <= dist_mem[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      known_q   <= '0;
      taken_q   <= '0;
      cost_q    <= '0;
      i_q       <= '0;
      u_q       <= '0;
      p1_v_q    <= 1'b0;
      p1_i_q    <= '0;
      found_q   <= 1'b0;
      best_q    <= '0;
      best_d_q  <= '0;
    end else begin
      p1_v_q <= cmd_i.pass_step;
      p1_i_q <= i_q;
      if (cmd_i.pass_step) i_q <= i_q + VW'(1);
      if (upd) known_q[p1_i_q] <= 1'b1;
      if (cand && (!found_q || (eff < best_d_q))) begin
        found_q  <= 1'b1;
        best_q   <= p1_i_q;
        best_d_q <= eff;
      end
      if (cmd_i.run_init) begin
        visited_q <= '0;
        known_q   <= '0;
        taken_q   <= '0;
        cost_q    <= '0;
      end
      if (cmd_i.take_src) begin
        u_q <= VW'(src_q);
        visited_q[VW'(src_q)] <= 1'b1;
        known_q[VW'(src_q)]   <= 1'b1;
        taken_q <= NW'(1);
        i_q     <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.take) begin
        u_q <= best_q;
        visited_q[best_q] <= 1'b1;
        taken_q <= taken_q + NW'(1);
        cost_q  <= cost_q + {{(COST_W-WW){best_d_q[WW-1]}}, best_d_q};
        i_q     <= '0;
        found_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      total_cost_o   <= cost_q;
      disconnected_o <= disc_i;
    end
  end

  always_comb begin
    status_o.clr_last   = (clr_idx_q == AW'(DEPTH - 1));
    status_o.add_upd    = in_range_q && (!edge_rd_q[WW] || (w_q < $signed(edge_rd_q[WW-1:0])));
    status_o.n_zero     = (n == '0);
    status_o.src_bad    = (int'(src_q) >= int'(n));
    status_o.issue_last = (i_q == VW'(int'(n) - 1));
    status_o.all_taken  = (taken_q == n);
    status_o.found      = found_q;
  end

  a_take_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> found_q && !visited_q[best_q])
    else $error("take without a fresh candidate");

endmodule

// ===== src/mst_ctrl.sv =====
// Controller: sequences clear sweep, edge update and Prim passes.
`timescale 1ns / 1ps

module mst_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mst_pkg::ACT_W-1:0]     action_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  mst_pkg::status_t              status_i,
  output mst_pkg::cmd_t                 cmd_o,
  output logic                          disc_o
);
  import mst_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_ADD_RD, ST_ADD_CHK, ST_ADD_BA,
    ST_RUN, ST_SRC, ST_PASS, ST_DRAIN, ST_EVAL, ST_FIN
  } state_e;

  state_e state_q;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLR:     cmd_o.clr_wr    = 1'b1;
      ST_IDLE:    cmd_o.cap       = accept;
      ST_ADD_RD:  cmd_o.add_rd    = 1'b1;
      ST_ADD_CHK: cmd_o.add_wr_ab = status_i.add_upd;
      ST_ADD_BA:  cmd_o.add_wr_ba = 1'b1;
      ST_RUN:     cmd_o.run_init  = 1'b1;
      ST_SRC:     cmd_o.take_src  = 1'b1;
      ST_PASS:    cmd_o.pass_step = 1'b1;
      ST_DRAIN:   ;
      ST_EVAL:    cmd_o.take = !status_i.all_taken && status_i.found;
      ST_FIN:     cmd_o.out_load  = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_o <= 1'b0;
      disc_o      <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        ST_CLR: if (status_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE: begin
          if (accept) begin
            unique case (action_e'(action_i))
              ACT_CLEAR: state_q <= ST_CLR;
              ACT_ADD:   state_q <= ST_ADD_RD;
              ACT_RUN:   state_q <= ST_RUN;
              ACT_NONE:  state_q <= ST_IDLE;
              default:   state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ADD_RD:  state_q <= ST_ADD_CHK;
        ST_ADD_CHK: state_q <= status_i.add_upd ? ST_ADD_BA : ST_IDLE;
        ST_ADD_BA:  state_q <= ST_IDLE;
        ST_RUN: begin
          if (status_i.n_zero) begin
            disc_o  <= 1'b0;
            state_q <= ST_FIN;
          end else if (status_i.src_bad) begin
            disc_o  <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_SRC;
          end
        end
        ST_SRC:   state_q <= ST_PASS;
        ST_PASS:  if (status_i.issue_last) state_q <= ST_DRAIN;
        ST_DRAIN: state_q <= ST_EVAL;
        ST_EVAL: begin
          if (status_i.all_taken) begin
            disc_o  <= 1'b0;
            state_q <= ST_FIN;
          end else if (!status_i.found) begin
            disc_o  <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_PASS;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("overlapping datapath commands");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o && state_q == ST_IDLE)
    else $error("result load did not present a result");

endmodule

// ===== src/mst_prim_total_cost.sv =====
// Top level: minimum spanning tree total cost over a dense edge store.
// Add edge: read, compare, then two mirrored writes to the edge memory when the new weight wins.
// Clear: one edge entry per cycle over all MAX_VERTICES*MAX_VERTICES entries.
// Run: each tree step walks one edge-memory row.
// After reset the same clearing pass runs before the first transaction is accepted.
`timescale 1ns / 1ps

module mst_prim_total_cost #(
  parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mst_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mst_pkg::ACT_W-1:0]          action_i,
  input  logic [mst_pkg::VTX_W-1:0]          vertex_a_i,
  input  logic [mst_pkg::VTX_W-1:0]          vertex_b_i,
  input  logic signed [mst_pkg::WIN_W-1:0]   edge_weight_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mst_pkg::COST_W-1:0]  total_cost_o,
  output logic                               disconnected_o
);
  import mst_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    disc;

  mst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .disc_o      (disc)
  );

  mst_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .edge_weight_i  (edge_weight_i),
    .cmd_i          (cmd),
    .disc_i         (disc),
    .status_o       (status),
    .total_cost_o   (total_cost_o),
    .disconnected_o (disconnected_o)
  );

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.pass_step && !cmd.take)
    else $error("accepting a transaction with a pass in flight");

endmodule
